/* rtl/core/sst_pkg.sv */
// Shared types and constants for the software timer slot table.
// Holds the function and status codes, register indexes and the control structs.
// No dependencies.
package sst_pkg;

   localparam int ADDR_MAX_W   = 6;
   localparam int HANDLE_MAX_W = 16;

   localparam logic signed [32:0] DAY_MS = 33'sd86400000;

   localparam logic [1:0] FN_TICK   = 2'd0;
   localparam logic [1:0] FN_ADD    = 2'd1;
   localparam logic [1:0] FN_REMOVE = 2'd2;
   localparam logic [1:0] FN_READ   = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FIRED     = 3'd1;
   localparam logic [2:0] ST_NONE      = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   localparam logic [1:0] CSR_MS_PER_TICK = 2'd0;
   localparam logic [1:0] CSR_CORR_ENABLE = 2'd1;
   localparam logic [1:0] CSR_CORR_INTVL  = 2'd2;
   localparam logic [1:0] CSR_CORR_AMOUNT = 2'd3;

   localparam logic [9:0]        RST_MS_PER_TICK = 10'd1;
   localparam logic [7:0]        RST_CORR_INTVL  = 8'd43;
   localparam logic signed [4:0] RST_CORR_AMOUNT = -5'sd1;

   typedef struct packed {
      logic                     rd_en;
      logic [ADDR_MAX_W-1:0]    rd_addr;
      logic                     wr_handle;
      logic                     wr_deadline;
      logic [ADDR_MAX_W-1:0]    wr_addr;
      logic [HANDLE_MAX_W-1:0]  wr_handle_data;
      logic signed [31:0]       wr_deadline_data;
   } mem_ctl_type;

   typedef struct packed {
      logic advance;
      logic correct;
   } clk_ctl_type;

endpackage

/* rtl/core/sst_slot_mem.sv */
// Slot storage: handle and deadline memories, one read port with registered data.
// Depends on sst_pkg for the memory control struct.
module sst_slot_mem #(
   parameter int SLOTS       = 16,
   parameter int HANDLE_BITS = 8
) (
   input  logic                    clock,
   input  sst_pkg::mem_ctl_type    ctl,
   output logic [HANDLE_BITS-1:0]  rd_handle,
   output logic signed [31:0]      rd_deadline
);
   import sst_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [HANDLE_BITS-1:0] handle_mem [SLOTS];
   logic signed [31:0]     deadline_mem [SLOTS];
   logic [HANDLE_BITS-1:0] rd_handle_ff;
   logic signed [31:0]     rd_deadline_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_handle) begin
         handle_mem[ctl.wr_addr[IDX_W-1:0]] <= ctl.wr_handle_data[HANDLE_BITS-1:0];
      end
      if (ctl.wr_deadline) begin
         deadline_mem[ctl.wr_addr[IDX_W-1:0]] <= ctl.wr_deadline_data;
      end
      if (ctl.rd_en) begin
         rd_handle_ff   <= handle_mem[ctl.rd_addr[IDX_W-1:0]];
         rd_deadline_ff <= deadline_mem[ctl.rd_addr[IDX_W-1:0]];
      end
   end

   assign rd_handle   = rd_handle_ff;
   assign rd_deadline = rd_deadline_ff;

endmodule

/* rtl/core/sst_day_clock.sv */
// Day clock, drift correction counter and configuration registers.
// Depends on sst_pkg for register indexes, reset values and the step struct.
module sst_day_clock (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [1:0]           csr_index,
   input  logic [9:0]           csr_data,
   input  sst_pkg::clk_ctl_type ctl,
   output logic signed [27:0]   day_clock,
   output logic                 day_wrap
);
   import sst_pkg::*;

   localparam logic signed [28:0] CLK_MAX = 29'sd134217727;
   localparam logic signed [28:0] CLK_MIN = -29'sd134217728;

   logic [9:0]         ms_per_tick_ff;
   logic               corr_enable_ff;
   logic [7:0]         corr_intvl_ff;
   logic signed [4:0]  corr_amount_ff;
   logic signed [27:0] clock_ff, clock_in;
   logic [7:0]         count_ff, count_in;
   logic               wrap_ff, wrap_in;
   logic signed [28:0] tick_sum;
   logic signed [28:0] corr_sum;
   logic [7:0]         count_next;

   function automatic logic signed [27:0] sat_clock(input logic signed [28:0] v);
      if (v > CLK_MAX) begin
         return CLK_MAX[27:0];
      end else if (v < CLK_MIN) begin
         return CLK_MIN[27:0];
      end
      return v[27:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_per_tick_ff <= RST_MS_PER_TICK;
         corr_enable_ff <= 1'b0;
         corr_intvl_ff  <= RST_CORR_INTVL;
         corr_amount_ff <= RST_CORR_AMOUNT;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MS_PER_TICK: ms_per_tick_ff <= csr_data;
            CSR_CORR_ENABLE: corr_enable_ff <= csr_data[0];
            CSR_CORR_INTVL:  corr_intvl_ff  <= csr_data[7:0];
            CSR_CORR_AMOUNT: corr_amount_ff <= $signed(csr_data[4:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      tick_sum   = $signed({clock_ff[27], clock_ff}) + $signed({19'd0, ms_per_tick_ff});
      corr_sum   = $signed({clock_ff[27], clock_ff})
                 + $signed({{24{corr_amount_ff[4]}}, corr_amount_ff});
      count_next = count_ff + 8'd1;
      clock_in   = clock_ff;
      count_in   = count_ff;
      wrap_in    = wrap_ff;
      if (ctl.advance) begin
         wrap_in  = (tick_sum >= $signed(DAY_MS[28:0]));
         clock_in = wrap_in ? 28'sd0 : sat_clock(tick_sum);
      end else if (ctl.correct && corr_enable_ff) begin
         if (count_next >= corr_intvl_ff) begin
            count_in = 8'd0;
            clock_in = sat_clock(corr_sum);
         end else begin
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff <= 28'sd0;
         count_ff <= 8'd0;
         wrap_ff  <= 1'b0;
      end else begin
         clock_ff <= clock_in;
         count_ff <= count_in;
         wrap_ff  <= wrap_in;
      end
   end

   assign day_clock = clock_ff;
   assign day_wrap  = wrap_ff;

endmodule

/* rtl/core/software_timer_slot_table.sv */
// Software timer slot table: sequencer that scans slot memory one slot per cycle
// when no output stall holds a tick scan. A tick's word waits in a
// one-entry hold register until the next fire or the end of the scan
// marks it last. One item at a time.
// Reset (synchronous) empties all slots through occupancy flags, zeroes the clock
// and counter and loads register defaults; no memory sweep is needed.
module software_timer_slot_table #(
   parameter int SLOTS       = 16,
   parameter int HANDLE_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [7:0]         req_handle,
   input  logic [26:0]        req_timeout_ms,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [7:0]         rsp_fired_handle,
   output logic [5:0]         rsp_slot_index,
   output logic signed [27:0] rsp_clock_ms,
   output logic               rsp_last,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [9:0]         csr_data
);
   import sst_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int HW    = (HANDLE_BITS < 8) ? HANDLE_BITS : 8;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic signed [32:0] DL_MIN = -33'sd2147483648;
   localparam logic signed [32:0] DL_MAX = 33'sd2147483647;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CLK  = 3'd1;
   localparam logic [2:0] S_CORR = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [1:0]             func_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   logic [26:0]            timeout_ff;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [SLOTS-1:0]       occ_ff, occ_in;
   logic                   pend_vld_ff, pend_vld_in;
   logic [2:0]             pend_status_ff, pend_status_in;
   logic [HANDLE_BITS-1:0] pend_handle_ff, pend_handle_in;
   logic [IDX_W-1:0]       pend_idx_ff, pend_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2:0]             rsp_status_ff;
   logic [7:0]             rsp_handle_ff;
   logic [5:0]             rsp_index_ff;
   logic signed [27:0]     rsp_clock_ff;
   logic                   rsp_last_ff;

   logic                   accept;
   logic                   out_free;
   logic [HANDLE_BITS-1:0] req_h;
   logic [HANDLE_BITS-1:0] rd_handle;
   logic signed [31:0]     rd_deadline;
   logic signed [27:0]     day_clock;
   logic                   day_wrap;
   logic                   occupied;
   logic [HANDLE_BITS-1:0] slot_h;
   logic signed [32:0]     dl_sub;
   logic signed [31:0]     dl_adj;
   logic signed [32:0]     add_sum;
   logic signed [31:0]     add_dl;
   logic                   fire;
   logic                   emit;
   logic [2:0]             emit_status;
   logic [HANDLE_BITS-1:0] emit_handle;
   logic [IDX_W-1:0]       emit_idx;
   logic                   emit_last;
   logic [7:0]             emit_handle8;
   logic [5:0]             emit_idx6;
   mem_ctl_type            mem_ctl;
   clk_ctl_type            clk_ctl;

   function automatic logic signed [31:0] sat_deadline(input logic signed [32:0] v);
      if (v > DL_MAX) begin
         return DL_MAX[31:0];
      end else if (v < DL_MIN) begin
         return DL_MIN[31:0];
      end
      return v[31:0];
   endfunction

   sst_slot_mem #(
      .SLOTS       (SLOTS),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_mem (
      .clock       (clock),
      .ctl         (mem_ctl),
      .rd_handle   (rd_handle),
      .rd_deadline (rd_deadline)
   );

   sst_day_clock u_clock (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .ctl       (clk_ctl),
      .day_clock (day_clock),
      .day_wrap  (day_wrap)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      req_h         = '0;
      req_h[HW-1:0] = req_handle[HW-1:0];
   end

   always_comb begin
      occupied = occ_ff[idx_ff];
      slot_h   = occupied ? rd_handle : '0;
      dl_sub   = $signed({rd_deadline[31], rd_deadline}) - DAY_MS;
      dl_adj   = day_wrap ? sat_deadline(dl_sub) : rd_deadline;
      fire     = occupied && (dl_adj <= $signed({{4{day_clock[27]}}, day_clock}));
      add_sum  = $signed({{5{day_clock[27]}}, day_clock}) + $signed({6'd0, timeout_ff});
      add_dl   = sat_deadline(add_sum);
   end

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      occ_in         = occ_ff;
      pend_vld_in    = pend_vld_ff;
      pend_status_in = pend_status_ff;
      pend_handle_in = pend_handle_ff;
      pend_idx_in    = pend_idx_ff;
      emit           = 1'b0;
      emit_status    = ST_OK;
      emit_handle    = '0;
      emit_idx       = '0;
      emit_last      = 1'b0;
      mem_ctl        = '0;
      clk_ctl        = '0;

      mem_ctl.wr_addr[IDX_W-1:0]               = idx_ff;
      mem_ctl.wr_handle_data[HANDLE_BITS-1:0]  = handle_ff;
      mem_ctl.wr_deadline_data                 = add_dl;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mem_ctl.rd_en = 1'b1;
               idx_in        = '0;
               unique case (req_func)
                  FN_TICK:   state_in = S_CLK;
                  FN_ADD:    state_in = S_SCAN;
                  FN_REMOVE: state_in = S_SCAN;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_CLK: begin
            clk_ctl.advance = 1'b1;
            state_in        = S_CORR;
         end
         S_CORR: begin
            clk_ctl.correct = 1'b1;
            state_in        = S_SCAN;
         end
         S_SCAN: begin
            if (func_ff == FN_TICK) begin
               if (!(fire && pend_vld_ff && !out_free)) begin
                  if (occupied && day_wrap) begin
                     mem_ctl.wr_deadline      = 1'b1;
                     mem_ctl.wr_deadline_data = dl_adj;
                  end
                  if (fire) begin
                     occ_in[idx_ff] = 1'b0;
                     if (pend_vld_ff) begin
                        emit        = 1'b1;
                        emit_status = pend_status_ff;
                        emit_handle = pend_handle_ff;
                        emit_idx    = pend_idx_ff;
                     end
                     pend_vld_in    = 1'b1;
                     pend_status_in = ST_FIRED;
                     pend_handle_in = slot_h;
                     pend_idx_in    = idx_ff;
                  end
                  if (idx_ff == LAST_IDX) begin
                     state_in = S_DONE;
                  end else begin
                     mem_ctl.rd_en                 = 1'b1;
                     mem_ctl.rd_addr[IDX_W-1:0]    = idx_ff + 1'b1;
                     idx_in                        = idx_ff + 1'b1;
                  end
               end
            end else if ((func_ff == FN_ADD && !occupied) ||
                         (func_ff == FN_REMOVE && slot_h == handle_ff)) begin
               if (func_ff == FN_ADD) begin
                  mem_ctl.wr_handle   = 1'b1;
                  mem_ctl.wr_deadline = 1'b1;
                  occ_in[idx_ff]      = (handle_ff != '0);
               end else begin
                  occ_in[idx_ff] = 1'b0;
               end
               pend_vld_in    = 1'b1;
               pend_status_in = ST_OK;
               pend_handle_in = '0;
               pend_idx_in    = idx_ff;
               state_in       = S_DONE;
            end else if (idx_ff == LAST_IDX) begin
               state_in = S_DONE;
            end else begin
               mem_ctl.rd_en              = 1'b1;
               mem_ctl.rd_addr[IDX_W-1:0] = idx_ff + 1'b1;
               idx_in                     = idx_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_last   = 1'b1;
               pend_vld_in = 1'b0;
               state_in    = S_IDLE;
               if (pend_vld_ff) begin
                  emit_status = pend_status_ff;
                  emit_handle = pend_handle_ff;
                  emit_idx    = pend_idx_ff;
               end else begin
                  unique case (func_ff)
                     FN_TICK:   emit_status = ST_NONE;
                     FN_ADD:    emit_status = ST_FULL;
                     FN_REMOVE: emit_status = ST_NOT_FOUND;
                     default:   emit_status = ST_OK;
                  endcase
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      emit_handle8                 = '0;
      emit_handle8[HW-1:0]         = emit_handle[HW-1:0];
      emit_idx6                    = '0;
      emit_idx6[IDX_W-1:0]         = emit_idx;
      rsp_valid_in                 = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      pend_status_ff <= pend_status_in;
      pend_handle_ff <= pend_handle_in;
      pend_idx_ff    <= pend_idx_in;
      if (accept) begin
         func_ff    <= req_func;
         handle_ff  <= req_h;
         timeout_ff <= req_timeout_ms;
      end
      if (emit) begin
         rsp_status_ff <= emit_status;
         rsp_handle_ff <= emit_handle8;
         rsp_index_ff  <= emit_idx6;
         rsp_clock_ff  <= day_clock;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_fired_handle = rsp_handle_ff;
   assign rsp_slot_index   = rsp_index_ff;
   assign rsp_clock_ms     = rsp_clock_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

/* tb/tb_software_timer_slot_table.sv */
// Testbench for software_timer_slot_table: directed and random words against a shadow table.
// A scoreboard class predicts every result word and checks each one as it is accepted.
// Depends on sst_pkg and the software_timer_slot_table RTL.
module tb_software_timer_slot_table;
   timeunit 1ns;
   timeprecision 1ps;
   import sst_pkg::*;

   localparam int     SLOTS            = 16;
   localparam int     HANDLE_BITS      = 8;
   localparam longint DAY_LEN_MS       = 64'sd86400000;
   localparam longint CLOCK_TOP        = 64'sd134217727;
   localparam longint CLOCK_BOTTOM     = -64'sd134217728;
   localparam longint DL_TOP           = 64'sd2147483647;
   localparam longint DL_BOTTOM        = -64'sd2147483648;
   localparam int     STALL_LIMIT      = 4000;
   localparam int     HOLD_CYCLES      = 400;
   localparam int     SETTLE_CYCLES    = 2 * SLOTS + 8;
   localparam int     RANDOM_PER_PHASE = 32;

   typedef struct packed {
      logic [2:0]         status;
      logic [7:0]         fired_handle;
      logic [5:0]         slot_index;
      logic signed [27:0] clock_ms;
      logic               last;
   } timer_word_type;

   class slot_table_shadow;
      logic [9:0]             tick_ms;
      logic                   corr_on;
      logic [7:0]             corr_period;
      logic signed [4:0]      corr_amount;
      logic [HANDLE_BITS-1:0] owner[SLOTS];
      longint                 deadline[SLOTS];
      longint                 now_ms;
      int unsigned            corr_ticks;
      timer_word_type         awaited_words[$];
      int                     errors;

      function new();
         tick_ms     = RST_MS_PER_TICK;
         corr_on     = 1'b0;
         corr_period = RST_CORR_INTVL;
         corr_amount = RST_CORR_AMOUNT;
         foreach (owner[i]) begin
            owner[i]    = '0;
            deadline[i] = 0;
         end
         now_ms     = 0;
         corr_ticks = 0;
         errors     = 0;
      endfunction

      function longint clamp(longint v, longint lo, longint hi);
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      function void push_due(logic [2:0] status, logic [7:0] fired, int idx, logic last);
         timer_word_type w;
         w.status       = status;
         w.fired_handle = fired;
         w.slot_index   = idx[5:0];
         w.clock_ms     = now_ms[27:0];
         w.last         = last;
         awaited_words.push_back(w);
      endfunction

      function void write_reg(logic [1:0] idx, logic [9:0] data);
         case (idx)
            CSR_MS_PER_TICK: tick_ms     = data;
            CSR_CORR_ENABLE: corr_on     = data[0];
            CSR_CORR_INTVL:  corr_period = data[7:0];
            CSR_CORR_AMOUNT: corr_amount = data[4:0];
            default: ;
         endcase
      endfunction

      function void apply_word(logic [1:0] func, logic [7:0] handle, logic [26:0] timeout);
         logic [HANDLE_BITS-1:0] h;
         longint                 next_ms;
         int                     hit;
         int                     fired_slots[$];
         h   = handle[HANDLE_BITS-1:0];
         hit = -1;
         case (func)
            FN_TICK: begin
               next_ms = now_ms + longint'(tick_ms);
               if (next_ms >= DAY_LEN_MS) begin
                  next_ms = 0;
                  foreach (owner[i])
                     if (owner[i] != 0)
                        deadline[i] = clamp(deadline[i] - DAY_LEN_MS, DL_BOTTOM, DL_TOP);
               end
               now_ms = clamp(next_ms, CLOCK_BOTTOM, CLOCK_TOP);
               if (corr_on) begin
                  corr_ticks = (corr_ticks + 1) & 8'hFF;
                  if (corr_ticks >= corr_period) begin
                     corr_ticks = 0;
                     now_ms = clamp(now_ms + corr_amount, CLOCK_BOTTOM, CLOCK_TOP);
                  end
               end
               foreach (owner[i])
                  if (owner[i] != 0 && deadline[i] <= now_ms) fired_slots.push_back(i);
               if (fired_slots.size() == 0) begin
                  push_due(ST_NONE, 8'h00, 0, 1'b1);
               end else begin
                  foreach (fired_slots[k]) begin
                     push_due(ST_FIRED, owner[fired_slots[k]], fired_slots[k],
                              k == fired_slots.size() - 1);
                     owner[fired_slots[k]] = '0;
                  end
               end
            end
            FN_ADD: begin
               foreach (owner[i]) if (hit < 0 && owner[i] == 0) hit = i;
               if (hit < 0) begin
                  push_due(ST_FULL, 8'h00, 0, 1'b1);
               end else begin
                  owner[hit]    = h;
                  deadline[hit] = clamp(now_ms + longint'(timeout), DL_BOTTOM, DL_TOP);
                  push_due(ST_OK, 8'h00, hit, 1'b1);
               end
            end
            FN_REMOVE: begin
               foreach (owner[i]) if (hit < 0 && owner[i] == h) hit = i;
               if (hit < 0) begin
                  push_due(ST_NOT_FOUND, 8'h00, 0, 1'b1);
               end else begin
                  owner[hit] = '0;
                  push_due(ST_OK, 8'h00, hit, 1'b1);
               end
            end
            default: push_due(ST_OK, 8'h00, 0, 1'b1);
         endcase
      endfunction

      function void check_word(timer_word_type got);
         timer_word_type want;
         if (awaited_words.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t unexpected word: status %0d handle %0d slot %0d clock %0d last %0d",
                        $time, got.status, got.fired_handle, got.slot_index, got.clock_ms,
                        got.last);
            return;
         end
         want = awaited_words.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t mismatch: expected status %0d handle %0d slot %0d clock %0d last %0d",
                        $time, want.status, want.fired_handle, want.slot_index, want.clock_ms,
                        want.last);
               $display("%0t             actual status %0d handle %0d slot %0d clock %0d last %0d",
                        $time, got.status, got.fired_handle, got.slot_index, got.clock_ms,
                        got.last);
            end
         end
      endfunction
   endclass

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_stall;
   logic [1:0]         req_func       = FN_READ;
   logic [7:0]         req_handle     = '0;
   logic [26:0]        req_timeout_ms = '0;
   logic               rsp_valid;
   logic               rsp_stall      = 1'b0;
   logic [2:0]         rsp_status;
   logic [7:0]         rsp_fired_handle;
   logic [5:0]         rsp_slot_index;
   logic signed [27:0] rsp_clock_ms;
   logic               rsp_last;
   logic               csr_write      = 1'b0;
   logic [1:0]         csr_index      = CSR_MS_PER_TICK;
   logic [9:0]         csr_data       = '0;

   slot_table_shadow table_shadow;
   timer_word_type   seen_word;
   int               idle_cycles   = 0;
   int               hold_requests = 0;
   int               hold_served   = 0;
   int               hold_left     = 0;
   int               pat_left      = 0;
   int               pat_mode      = 0;
   int               burst_left    = 0;

   software_timer_slot_table #(
      .SLOTS       (SLOTS),
      .HANDLE_BITS (HANDLE_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_handle       (req_handle),
      .req_timeout_ms   (req_timeout_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_fired_handle (rsp_fired_handle),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_clock_ms     (rsp_clock_ms),
      .rsp_last         (rsp_last),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   // check accepted words, then pick the next stall value
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_word.status       = rsp_status;
         seen_word.fired_handle = rsp_fired_handle;
         seen_word.slot_index   = rsp_slot_index;
         seen_word.clock_ms     = rsp_clock_ms;
         seen_word.last         = rsp_last;
         table_shadow.check_word(seen_word);
      end
      if (hold_served < hold_requests) begin
         hold_served++;
         hold_left = HOLD_CYCLES;
      end
      if (pat_left == 0) begin
         pat_mode = $urandom_range(0, 3);
         pat_left = $urandom_range(16, 96);
      end
      pat_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (pat_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= (pat_left % 8) < 5;
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL software_timer_slot_table");
         $finish;
      end
   end

   task automatic idle_gap(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_word(logic [1:0] func, logic [7:0] handle, logic [26:0] timeout);
      req_valid      <= 1'b1;
      req_func       <= func;
      req_handle     <= handle;
      req_timeout_ms <= timeout;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      table_shadow.apply_word(func, handle, timeout);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (table_shadow.awaited_words.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [9:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      table_shadow.write_reg(idx, data);
   endtask

   task automatic program_regs(logic [9:0] tick, logic enable, logic [7:0] period,
                               logic [4:0] amount);
      write_reg(CSR_MS_PER_TICK, tick);
      write_reg(CSR_CORR_ENABLE, {9'd0, enable});
      write_reg(CSR_CORR_INTVL, {2'd0, period});
      write_reg(CSR_CORR_AMOUNT, {5'd0, amount});
      csr_write <= 1'b0;
   endtask

   task automatic send_random_word();
      int          pick;
      int          span;
      logic [1:0]  func;
      logic [7:0]  handle;
      logic [26:0] timeout;
      pick = $urandom_range(0, 99);
      span = table_shadow.tick_ms * 24 + 64;
      if (pick < 38) func = FN_ADD;
      else if (pick < 72) func = FN_TICK;
      else if (pick < 92) func = FN_REMOVE;
      else func = FN_READ;
      handle = 8'($urandom_range(1, 255));
      if ($urandom_range(0, 15) == 0) handle = 8'h00;
      // aim most removes at a slot that is likely live
      if (func == FN_REMOVE && $urandom_range(0, 3) != 0)
         handle = table_shadow.owner[$urandom_range(0, SLOTS - 1)];
      case ($urandom_range(0, 9))
         0:       timeout = 27'($urandom());
         1:       timeout = 27'h7FFFFFF;
         2:       timeout = '0;
         default: timeout = 27'($urandom_range(0, span));
      endcase
      if (func != FN_ADD && $urandom_range(0, 1) != 0) timeout = 27'($urandom());
      send_word(func, handle, timeout);
   endtask

   task automatic send_random(int count, int drain_at);
      for (int k = 0; k < count; k++) begin
         if (k == drain_at) wait_drained();
         if (burst_left == 0) begin
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
            burst_left = $urandom_range(1, 16);
         end
         burst_left--;
         send_random_word();
      end
   endtask

   initial begin
      table_shadow = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_word(FN_READ, 8'hFF, 27'h7FFFFFF);
      send_word(FN_REMOVE, 8'hA5, 27'd0);
      send_word(FN_REMOVE, 8'h00, 27'd0);
      send_word(FN_ADD, 8'h00, 27'h7FFFFFF);
      send_word(FN_ADD, 8'hFF, 27'd0);
      send_word(FN_ADD, 8'h01, 27'h7FFFFFF);
      send_word(FN_TICK, 8'h00, 27'd0);
      for (int i = 0; i < SLOTS; i++) send_word(FN_ADD, 8'(8'h10 + i), 27'(3 * i));
      send_word(FN_REMOVE, 8'h00, 27'd0);
      send_word(FN_TICK, 8'h00, 27'd0);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0:       program_regs(10'd1, 1'b1, 8'd0, 5'b10000);
            1:       program_regs(10'd1000, 1'b1, 8'd255, 5'd8);
            2:       program_regs(10'd1000, 1'b0, 8'd255, 5'b11000);
            3:       program_regs(10'd0, 1'b1, 8'd3, 5'd15);
            4:       program_regs(10'd1023, 1'b1, 8'd200, 5'b11111);
            default: program_regs(10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
                                  8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
         endcase
         if (p == 2) hold_requests++;
         send_random(RANDOM_PER_PHASE, (p == 4) ? 19 : -1);
         wait_drained();
      end

      program_regs(10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
                   8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
      send_random(20, -1);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (table_shadow.errors == 0 && table_shadow.awaited_words.size() == 0) begin
         $display("PASS software_timer_slot_table");
      end else begin
         $display("FAIL software_timer_slot_table");
      end
      $finish;
   end

endmodule
